FILE: rtl/ttv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent vector package
// Shared types and constants for the tangent vector core.
// ----------------------------------------------------------------------------
package ttv_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int RAW_WIDTH   = 2 * COORD_WIDTH + 3;
	localparam int TAN_WIDTH   = 16;
	localparam int NORM_BITS   = 30;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] pos_x;
		logic signed [COORD_WIDTH-1:0] pos_y;
		logic signed [COORD_WIDTH-1:0] pos_z;
		logic signed [COORD_WIDTH-1:0] tex_u;
		logic signed [COORD_WIDTH-1:0] tex_v;
	} vertex_t;

	typedef struct packed {
		logic signed [TAN_WIDTH-1:0] tan_x;
		logic signed [TAN_WIDTH-1:0] tan_y;
		logic signed [TAN_WIDTH-1:0] tan_z;
		logic                        degenerate;
		logic                        last_copy;
	} tangent_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_SHIFT,
		ST_SQRT,
		ST_DIV,
		ST_EMIT
	} back_state_t;

endpackage

FILE: rtl/ttv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tangent vector front end
// Holds the first two vertices of a triangle and forms the unnormalized
// tangent and determinant sign on the third.
// ----------------------------------------------------------------------------
module ttv_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  ttv_pkg::vertex_t                     in_vtx,
	output logic                                 q_valid,
	input  logic                                 q_stall,
	output logic signed [ttv_pkg::RAW_WIDTH-1:0] q_tx,
	output logic signed [ttv_pkg::RAW_WIDTH-1:0] q_ty,
	output logic signed [ttv_pkg::RAW_WIDTH-1:0] q_tz,
	output logic                                 q_degen
);
	import ttv_pkg::*;

	localparam int TW = RAW_WIDTH;
	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;

	logic [1:0] phase_q;
	logic signed [COORD_WIDTH-1:0] v1_q [5];
	logic signed [COORD_WIDTH-1:0] v2_q [5];
	logic signed [DW-1:0] dp1_s1 [3];
	logic signed [DW-1:0] dp2_s1 [3];
	logic signed [DW-1:0] du1_s1, dv1_s1, du2_s1, dv2_s1;
	logic signed [PW-1:0] pa_s2 [4];
	logic signed [PW-1:0] pb_s2 [4];
	logic [2:0] cnt_q;
	logic       busy_q;
	logic signed [TW-1:0] t_q [2];
	logic                 dneg_q, dzero_q;
	logic signed [COORD_WIDTH-1:0] f_in [5];
	logic accept;
	logic signed [PW:0] det_w;
	logic signed [TW-1:0] tz_w;

	assign f_in[0] = in_vtx.pos_x;
	assign f_in[1] = in_vtx.pos_y;
	assign f_in[2] = in_vtx.pos_z;
	assign f_in[3] = in_vtx.tex_u;
	assign f_in[4] = in_vtx.tex_v;

	assign in_stall = busy_q || q_valid;
	assign accept = in_valid && !in_stall;

	// cnt: 0 determinant products, 1 x products, 2 y products, 3 z products,
	// 4 results registered toward the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			busy_q  <= 1'b0;
			cnt_q   <= 3'd0;
			q_valid <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				v1_q[i] <= '0;
				v2_q[i] <= '0;
			end
		end else begin
			if (q_valid && !q_stall)
				q_valid <= 1'b0;
			if (accept) begin
				if (phase_q == 2'd2) begin
					phase_q <= 2'd0;
					busy_q  <= 1'b1;
					cnt_q   <= 3'd0;
				end else if (phase_q == 2'd1) begin
					phase_q <= 2'd2;
					for (int i = 0; i < 5; i++) v2_q[i] <= f_in[i];
				end else begin
					phase_q <= 2'd1;
					for (int i = 0; i < 5; i++) v1_q[i] <= f_in[i];
				end
			end
			if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q  <= 1'b0;
					q_valid <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == 2'd2) begin
			for (int i = 0; i < 3; i++) begin
				dp1_s1[i] <= DW'(v2_q[i]) - DW'(v1_q[i]);
				dp2_s1[i] <= DW'(f_in[i]) - DW'(v1_q[i]);
			end
			du1_s1 <= DW'(v2_q[3]) - DW'(v1_q[3]);
			dv1_s1 <= DW'(v2_q[4]) - DW'(v1_q[4]);
			du2_s1 <= DW'(f_in[3]) - DW'(v1_q[3]);
			dv2_s1 <= DW'(f_in[4]) - DW'(v1_q[4]);
		end
	end

	// One pair of products per cycle: determinant, then each component.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			unique case (cnt_q)
				3'd0: begin
					pa_s2[0] <= du1_s1 * dv2_s1;
					pb_s2[0] <= dv1_s1 * du2_s1;
				end
				3'd1: begin
					pa_s2[1] <= dv2_s1 * dp1_s1[0];
					pb_s2[1] <= dv1_s1 * dp2_s1[0];
				end
				3'd2: begin
					pa_s2[2] <= dv2_s1 * dp1_s1[1];
					pb_s2[2] <= dv1_s1 * dp2_s1[1];
				end
				3'd3: begin
					pa_s2[3] <= dv2_s1 * dp1_s1[2];
					pb_s2[3] <= dv1_s1 * dp2_s1[2];
				end
				default: ;
			endcase
		end
	end

	assign det_w = (PW+1)'(pa_s2[0]) - (PW+1)'(pb_s2[0]);

	always_ff @(posedge clk) begin
		if (busy_q) begin
			unique case (cnt_q)
				3'd1: begin
					dneg_q  <= det_w[PW];
					dzero_q <= (det_w == '0);
				end
				3'd2: t_q[0] <= TW'(pa_s2[1]) - TW'(pb_s2[1]);
				3'd3: t_q[1] <= TW'(pa_s2[2]) - TW'(pb_s2[2]);
				default: ;
			endcase
		end
	end

	// The z component is taken straight from its products in the last cycle.
	assign tz_w = TW'(pa_s2[3]) - TW'(pb_s2[3]);

	always_ff @(posedge clk) begin
		if (busy_q && cnt_q == 3'd4) begin
			q_tx    <= dneg_q ? -t_q[0] : t_q[0];
			q_ty    <= dneg_q ? -t_q[1] : t_q[1];
			q_tz    <= dneg_q ? -tz_w : tz_w;
			q_degen <= dzero_q;
		end
	end

endmodule

FILE: rtl/ttv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tangent vector back end
// Normalizes the tangent with an iterative square root and divider (a degenerate
// tangent skips both and gives zero), then sends three copies of the result.
// ----------------------------------------------------------------------------
module ttv_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	output logic                                 q_stall,
	input  logic signed [ttv_pkg::RAW_WIDTH-1:0] q_tx,
	input  logic signed [ttv_pkg::RAW_WIDTH-1:0] q_ty,
	input  logic signed [ttv_pkg::RAW_WIDTH-1:0] q_tz,
	input  logic                                 q_degen,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output ttv_pkg::tangent_t                    out_tan
);
	import ttv_pkg::*;

	localparam int TW = RAW_WIDTH;
	localparam int MW = TW;
	localparam int LW = $clog2(MW + 1);
	localparam int AW = NORM_BITS;
	localparam int SW = 2 * AW + 2;
	localparam int NW = AW + 16;

	back_state_t st_q, st_d;
	logic [MW-1:0] m_q [3];
	logic [2:0]    neg_q;
	logic          degen_q;
	logic [AW-1:0] a_q [3];
	logic [SW-1:0] sum_q;
	logic [SW-1:0] rem_q;
	logic [AW:0]   root_q;
	logic [5:0]    it_q;
	logic [1:0]    comp_q;
	logic [NW-1:0] num_q;
	logic [NW:0]   drem_q;
	logic [15:0]   quo_q;
	logic [15:0]   res_q [3];
	logic [1:0]    copy_q;
	logic [LW-1:0] nlen;
	logic [MW-1:0] mor;
	logic [SW-1:0] trial;
	logic [NW:0]   dtrial;
	logic [NW:0]   dvs;
	logic [2*AW-1:0] sq_w [3];

	assign q_stall = (st_q != ST_IDLE);

	always_comb begin
		mor = m_q[0] | m_q[1] | m_q[2];
		nlen = '0;
		for (int i = 0; i < MW; i++)
			if (mor[i]) nlen = LW'(i + 1);
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (q_valid) st_d = ST_MAG;
			ST_MAG:   st_d = degen_q ? ST_EMIT : ST_SHIFT;
			ST_SHIFT: st_d = ST_SQRT;
			ST_SQRT:  if (it_q == 6'(AW+2)) st_d = ST_DIV;
			ST_DIV:   if (comp_q == 2'd2 && it_q == 6'(NW)) st_d = ST_EMIT;
			ST_EMIT:  if (!out_stall && copy_q == 2'd2) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		out_valid = (st_q == ST_EMIT);
		out_tan.tan_x = res_q[0];
		out_tan.tan_y = res_q[1];
		out_tan.tan_z = res_q[2];
		out_tan.degenerate = degen_q;
		out_tan.last_copy = (copy_q == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			copy_q <= 2'd0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_EMIT && !out_stall)
				copy_q <= (copy_q == 2'd2) ? 2'd0 : copy_q + 2'd1;
		end
	end

	// The root is built over AW+1 bit pairs, from the top pair of the sum down.
	always_comb begin
		trial  = SW'({root_q, 2'b01}) << (2 * (AW + 1 - 32'(it_q)));
		dvs    = (NW+1)'({root_q, 1'b0});
		dtrial = {drem_q[NW-1:0], num_q[NW-1]};
		for (int i = 0; i < 3; i++)
			sq_w[i] = a_q[i] * a_q[i];
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (q_valid) begin
				m_q[0] <= q_tx[TW-1] ? MW'(-q_tx) : MW'(q_tx);
				m_q[1] <= q_ty[TW-1] ? MW'(-q_ty) : MW'(q_ty);
				m_q[2] <= q_tz[TW-1] ? MW'(-q_tz) : MW'(q_tz);
				neg_q  <= {q_tz[TW-1], q_ty[TW-1], q_tx[TW-1]};
				degen_q <= q_degen || (q_tx == '0 && q_ty == '0 && q_tz == '0);
			end
			ST_MAG: begin
				for (int i = 0; i < 3; i++) begin
					if (32'(nlen) > AW)
						a_q[i] <= AW'(m_q[i] >> (32'(nlen) - AW));
					else
						a_q[i] <= AW'(m_q[i] << (AW - 32'(nlen)));
					res_q[i] <= '0;
				end
			end
			ST_SHIFT: begin
				// Squares are formed here once, before the root iterations.
				sum_q  <= SW'(sq_w[0]) + SW'(sq_w[1]) + SW'(sq_w[2]);
				root_q <= '0;
				it_q   <= 6'd0;
			end
			ST_SQRT: begin
				if (it_q == 6'd0) begin
					rem_q <= sum_q;
					it_q  <= 6'd1;
				end else if (it_q == 6'(AW+2)) begin
					comp_q <= 2'd0;
					it_q   <= 6'd0;
					if (root_q == '0) root_q <= (AW+1)'(1);
				end else begin
					// Digit-by-digit root: one result bit each cycle.
					if (rem_q >= trial) begin
						rem_q  <= rem_q - trial;
						root_q <= {root_q[AW-1:0], 1'b1};
					end else begin
						root_q <= {root_q[AW-1:0], 1'b0};
					end
					it_q <= it_q + 6'd1;
				end
			end
			ST_DIV: begin
				if (it_q == 6'd0) begin
					num_q  <= NW'({a_q[comp_q], 15'd0}) + NW'(root_q);
					drem_q <= '0;
					quo_q  <= '0;
					it_q   <= 6'd1;
				end else begin
					// Restoring division, one quotient bit per cycle.
					if (dtrial >= dvs) begin
						drem_q <= dtrial - dvs;
						quo_q  <= {quo_q[14:0], 1'b1};
					end else begin
						drem_q <= dtrial;
						quo_q  <= {quo_q[14:0], 1'b0};
					end
					num_q <= num_q << 1;
					if (it_q == 6'(NW)) begin
						res_q[comp_q] <= neg_q[comp_q]
							? 16'(17'h10000 - 17'({dtrial >= dvs ? 1'b1 : 1'b0} | 17'(quo_q) << 1))
							: 16'({quo_q[14:0], dtrial >= dvs});
						comp_q <= comp_q + 2'd1;
						it_q   <= 6'd0;
					end else begin
						it_q <= it_q + 6'd1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/triangle_tangent_vector_core.sv
`timescale 1ns / 1ps
// A degenerate triangle skips the square root and divide. After the first copy of
// a triangle, the other two copies follow on the next cycles unless the output
// stalls. The back end, an iterative square root and a restoring divide for each
// component, takes a new triangle only after sending the last copy of the one
// before; the front end can meanwhile accept the next triangle's vertices. Reset:
// arst_n clears vertex phase, held vertices, front-end control, FSM state, copy count.
// ----------------------------------------------------------------------------
// Triangle tangent vector core
// Front end forms the tangent, back end normalizes and emits three copies.
// ----------------------------------------------------------------------------
module triangle_tangent_vector_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ttv_pkg::vertex_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ttv_pkg::tangent_t out_data
);
	import ttv_pkg::*;

	logic                        q_valid, q_stall, q_degen;
	logic signed [RAW_WIDTH-1:0] q_tx, q_ty, q_tz;

	ttv_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_vtx(in_data),
		.q_valid, .q_stall, .q_tx, .q_ty, .q_tz, .q_degen
	);

	ttv_back u_back (
		.clk, .arst_n, .q_valid, .q_stall, .q_tx, .q_ty, .q_tz, .q_degen,
		.out_valid, .out_stall, .out_tan(out_data)
	);

endmodule

FILE: rtl/ttv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tangent vector port checker
// Watches the ports of the core for handshake and result rules.
// ----------------------------------------------------------------------------
module ttv_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input ttv_pkg::tangent_t out_data
);
	import ttv_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |->
			out_data.tan_x == '0 && out_data.tan_y == '0 && out_data.tan_z == '0)
		else $error("degenerate result is not zero");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.tan_x <= 16'sd16384 && out_data.tan_x >= -16'sd16384)
		else $error("tangent x out of range");

endmodule

bind triangle_tangent_vector_core ttv_checker u_ttv_checker (
	.clk, .arst_n, .out_valid, .out_stall, .out_data
);
